[sv/idpm_pkg.sv]
// ----------------------------------------------------------------------------
// idpm_pkg
// Shared types, widths and codes for the interval domain point membership
// block.
// ----------------------------------------------------------------------------
`default_nettype none

package idpm_pkg;

    localparam int COORD_W   = 16;
    localparam int OFF_W     = 10;
    localparam int SLOT_W    = 4;
    localparam int CNT_IN_W  = 5;
    localparam int OP_W      = 2;
    localparam int KIND_W    = 2;
    localparam int ERR_W     = 2;
    localparam int CFG_IDX_W = 3;
    localparam int ENTRY_W   = 2 * COORD_W;

    localparam logic [OP_W-1:0] OP_WR_IVL = 2'd0;
    localparam logic [OP_W-1:0] OP_WR_CNT = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

    localparam logic [KIND_W-1:0] KIND_RECT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_IVL  = 2'd1;

    localparam logic [ERR_W-1:0] ERR_NONE = 2'd0;
    localparam logic [ERR_W-1:0] ERR_KIND = 2'd1;
    localparam logic [ERR_W-1:0] ERR_LINE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_LINE_FIRST  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_LAST   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_FIRST   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_LAST    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DOMAIN_KIND = 3'd4;

    typedef struct packed {
        logic signed [COORD_W-1:0] line_first;
        logic signed [COORD_W-1:0] line_last;
        logic signed [COORD_W-1:0] col_first;
        logic signed [COORD_W-1:0] col_last;
        logic [KIND_W-1:0]         domain_kind;
    } t_cfg;

endpackage

`default_nettype wire

[sv/idpm_in_if.sv]
// ----------------------------------------------------------------------------
// idpm_in_if
// Item channel: interval writes, line count writes and point queries.
// ----------------------------------------------------------------------------
`default_nettype none

interface idpm_in_if;
    logic                                valid;
    logic                                ready;
    logic [idpm_pkg::OP_W-1:0]           operation;
    logic [idpm_pkg::OFF_W-1:0]          line_offset;
    logic [idpm_pkg::SLOT_W-1:0]         slot;
    logic [idpm_pkg::COORD_W-1:0]        interval_left;
    logic [idpm_pkg::COORD_W-1:0]        interval_right;
    logic [idpm_pkg::CNT_IN_W-1:0]       count;
    logic signed [idpm_pkg::COORD_W-1:0] point_line;
    logic signed [idpm_pkg::COORD_W-1:0] point_col;

    modport source (
        output valid, operation, line_offset, slot, interval_left, interval_right,
               count, point_line, point_col,
        input  ready
    );
    modport sink (
        input  valid, operation, line_offset, slot, interval_left, interval_right,
               count, point_line, point_col,
        output ready
    );
endinterface

`default_nettype wire

[sv/idpm_out_if.sv]
// ----------------------------------------------------------------------------
// idpm_out_if
// Result channel: membership flag and error code, one per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface idpm_out_if;
    logic                           valid;
    logic                           ready;
    logic                           inside_res;
    logic [idpm_pkg::ERR_W-1:0]     error;

    modport source (output valid, inside_res, error, input ready);
    modport sink   (input valid, inside_res, error, output ready);
endinterface

`default_nettype wire

[sv/interval_domain_point_membership.sv]
// ----------------------------------------------------------------------------
// interval_domain_point_membership
// Point membership test for a run-length interval domain. Line counts and
// intervals live in two synchronous RAMs; a query scans one line's intervals,
// one RAM read per cycle.
//
//   channel  | dir | handshake     | payload
//   ---------+-----+---------------+------------------------------------------
//   i_in     | in  | valid/ready   | operation, line_offset, slot, intervals,
//            |     |               | count, point_line, point_col
//   o_out    | out | valid/ready   | inside_res, error
//   i_cfg_*  | in  | write enable  | register index, 16-bit data
//
// One item at a time: i_in.ready is high only in IDLE. Writes and queries
// answered without a scan go from EXEC to RESP; an interval query goes
// through EXEC and CNT, then SCAN, which reads at most MAX_INTERVALS
// intervals (none for an empty line), then RESP, where the result register
// is loaded.
// After reset a clearing pass zeroes every line count RAM entry with
// i_in.ready low. The result register frees the block while a result waits,
// until the next result is due.
// ----------------------------------------------------------------------------
`default_nettype none

module interval_domain_point_membership #(
    parameter int MAX_LINES     = 1024,
    parameter int MAX_INTERVALS = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [idpm_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [idpm_pkg::COORD_W-1:0]      i_cfg_data,
    idpm_in_if.sink                                i_in,
    idpm_out_if.source                             o_out
);

    localparam int LW = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
    localparam int IW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
    localparam int CW = $clog2(MAX_INTERVALS + 1);
    localparam int CRD = idpm_pkg::COORD_W;

    localparam logic [CRD:0]    LINES_LIM = (CRD + 1)'(MAX_LINES);
    localparam logic [8:0]      IVL_LIM   = 9'(MAX_INTERVALS);
    localparam logic [LW-1:0]   LAST_LINE = LW'(MAX_LINES - 1);
    localparam logic [CW-1:0]   IVL_MAX   = CW'(MAX_INTERVALS);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_EXEC  = 3'd2;
    localparam logic [2:0] ST_CNT   = 3'd3;
    localparam logic [2:0] ST_SCAN  = 3'd4;
    localparam logic [2:0] ST_RESP  = 3'd5;

    idpm_pkg::t_cfg cfg;

    logic [2:0]                          r_state, n_state;
    logic [LW-1:0]                       r_clr;
    logic [idpm_pkg::OP_W-1:0]           r_op;
    logic [idpm_pkg::OFF_W-1:0]          r_loff;
    logic [idpm_pkg::SLOT_W-1:0]         r_slot;
    logic [CRD-1:0]                      r_left;
    logic [CRD-1:0]                      r_right;
    logic [idpm_pkg::CNT_IN_W-1:0]       r_cnt_in;
    logic signed [CRD-1:0]               r_pl;
    logic signed [CRD-1:0]               r_pc;
    logic [CRD-1:0]                      r_row, n_row;
    logic [CRD-1:0]                      r_rel, n_rel;
    logic [CW-1:0]                       r_idx, n_idx;
    logic [CW-1:0]                       r_cnt, n_cnt;
    logic                                r_inside, n_inside;
    logic [idpm_pkg::ERR_W-1:0]          r_err, n_err;
    logic                                r_ov;
    logic                                r_o_inside;
    logic [idpm_pkg::ERR_W-1:0]          r_o_err;

    logic                                w_accept;
    logic                                w_load;
    logic [CRD-1:0]                      w_loff;
    logic [8:0]                          w_slot;
    logic                                w_line_bad;
    logic                                w_slot_ok;
    logic [CW-1:0]                       w_cnt_clamp;
    logic                                w_box;
    logic [CRD-1:0]                      w_row;
    logic [CRD-1:0]                      w_rel;
    logic                                w_row_bad;
    logic [CW-1:0]                       w_idx_nx;
    logic [CRD-1:0]                      w_left;
    logic [CRD-1:0]                      w_right;

    logic                                cm_we;
    logic [LW-1:0]                       cm_waddr;
    logic [CW-1:0]                       cm_wdata;
    logic [LW-1:0]                       cm_raddr;
    logic [CW-1:0]                       cm_rdata;
    logic                                im_we;
    logic [LW+IW-1:0]                    im_waddr;
    logic [idpm_pkg::ENTRY_W-1:0]        im_wdata;
    logic [LW+IW-1:0]                    im_raddr;
    logic [idpm_pkg::ENTRY_W-1:0]        im_rdata;

    idpm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    idpm_ram #(.AW(LW), .DW(CW)) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (cm_we),
        .i_waddr (cm_waddr),
        .i_wdata (cm_wdata),
        .i_raddr (cm_raddr),
        .o_rdata (cm_rdata)
    );

    idpm_ram #(.AW(LW + IW), .DW(idpm_pkg::ENTRY_W)) u_ivl_ram (
        .i_clk   (i_clk),
        .i_we    (im_we),
        .i_waddr (im_waddr),
        .i_wdata (im_wdata),
        .i_raddr (im_raddr),
        .o_rdata (im_rdata)
    );

    assign i_in.ready = (r_state == ST_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_load     = (r_state == ST_RESP) && (!r_ov || o_out.ready);

    assign w_loff      = {{(CRD - idpm_pkg::OFF_W){1'b0}}, r_loff};
    assign w_slot      = {{(9 - idpm_pkg::SLOT_W){1'b0}}, r_slot};
    assign w_line_bad  = {1'b0, w_loff} >= LINES_LIM;
    assign w_slot_ok   = w_slot < IVL_LIM;
    assign w_cnt_clamp = ({4'b0, r_cnt_in} > IVL_LIM) ? IVL_MAX : CW'(r_cnt_in);

    assign w_box = ($signed(r_pl) >= $signed(cfg.line_first)) &&
                   ($signed(r_pl) <= $signed(cfg.line_last)) &&
                   ($signed(r_pc) >= $signed(cfg.col_first)) &&
                   ($signed(r_pc) <= $signed(cfg.col_last));
    assign w_row     = r_pl - cfg.line_first;
    assign w_rel     = r_pc - cfg.col_first;
    assign w_row_bad = {1'b0, w_row} >= LINES_LIM;

    assign w_idx_nx = r_idx + CW'(1);
    assign w_left   = im_rdata[CRD-1:0];
    assign w_right  = im_rdata[2*CRD-1:CRD];

    assign im_waddr = {w_loff[LW-1:0], w_slot[IW-1:0]};
    assign im_wdata = {r_right, r_left};
    assign im_raddr = {r_row[LW-1:0], n_idx[IW-1:0]};

    always_comb begin
        n_state  = r_state;
        n_row    = r_row;
        n_rel    = r_rel;
        n_idx    = r_idx;
        n_cnt    = r_cnt;
        n_inside = r_inside;
        n_err    = r_err;
        cm_we    = 1'b0;
        cm_waddr = w_loff[LW-1:0];
        cm_wdata = w_cnt_clamp;
        cm_raddr = w_row[LW-1:0];
        im_we    = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                cm_we    = 1'b1;
                cm_waddr = r_clr;
                cm_wdata = '0;
                if (r_clr == LAST_LINE) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_inside = 1'b0;
                n_err    = idpm_pkg::ERR_NONE;
                n_state  = ST_RESP;
                case (r_op)
                    idpm_pkg::OP_WR_IVL: begin
                        if (w_line_bad) begin
                            n_err = idpm_pkg::ERR_LINE;
                        end else begin
                            im_we = w_slot_ok;
                        end
                    end
                    idpm_pkg::OP_WR_CNT: begin
                        if (w_line_bad) begin
                            n_err = idpm_pkg::ERR_LINE;
                        end else begin
                            cm_we = 1'b1;
                        end
                    end
                    idpm_pkg::OP_QUERY: begin
                        if (w_box) begin
                            if (cfg.domain_kind == idpm_pkg::KIND_RECT) begin
                                n_inside = 1'b1;
                            end else if (cfg.domain_kind == idpm_pkg::KIND_IVL) begin
                                if (w_row_bad) begin
                                    n_err = idpm_pkg::ERR_LINE;
                                end else begin
                                    n_row   = w_row;
                                    n_rel   = w_rel;
                                    n_state = ST_CNT;
                                end
                            end else begin
                                n_err = idpm_pkg::ERR_KIND;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            ST_CNT: begin
                n_cnt = cm_rdata;
                n_idx = '0;
                if (cm_rdata == '0) begin
                    n_state = ST_RESP;
                end else begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_rel < w_left) begin
                    n_state = ST_RESP;
                end else if (r_rel <= w_right) begin
                    n_inside = 1'b1;
                    n_state  = ST_RESP;
                end else if (w_idx_nx == r_cnt) begin
                    n_state = ST_RESP;
                end else begin
                    n_idx = w_idx_nx;
                end
            end
            ST_RESP: begin
                if (w_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + LW'(1);
            end
            if (w_load) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op     <= i_in.operation;
            r_loff   <= i_in.line_offset;
            r_slot   <= i_in.slot;
            r_left   <= i_in.interval_left;
            r_right  <= i_in.interval_right;
            r_cnt_in <= i_in.count;
            r_pl     <= i_in.point_line;
            r_pc     <= i_in.point_col;
        end
        r_row    <= n_row;
        r_rel    <= n_rel;
        r_idx    <= n_idx;
        r_cnt    <= n_cnt;
        r_inside <= n_inside;
        r_err    <= n_err;
        if (w_load) begin
            r_o_inside <= r_inside;
            r_o_err    <= r_err;
        end
    end

    assign o_out.valid      = r_ov;
    assign o_out.inside_res = r_o_inside;
    assign o_out.error      = r_o_err;

endmodule

`default_nettype wire

[sv/idpm_ram.sv]
// ----------------------------------------------------------------------------
// idpm_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module idpm_ram #(
    parameter int AW = 10,
    parameter int DW = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [2**AW];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[sv/idpm_cfg.sv]
// ----------------------------------------------------------------------------
// idpm_cfg
// Configuration registers: bounding box and domain kind.
// ----------------------------------------------------------------------------
`default_nettype none

module idpm_cfg (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_we,
    input  wire logic [idpm_pkg::CFG_IDX_W-1:0]    i_idx,
    input  wire logic [idpm_pkg::COORD_W-1:0]      i_data,
    output idpm_pkg::t_cfg                         o_cfg
);

    idpm_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_we) begin
            case (i_idx)
                idpm_pkg::CFG_LINE_FIRST:  r_cfg.line_first  <= i_data;
                idpm_pkg::CFG_LINE_LAST:   r_cfg.line_last   <= i_data;
                idpm_pkg::CFG_COL_FIRST:   r_cfg.col_first   <= i_data;
                idpm_pkg::CFG_COL_LAST:    r_cfg.col_last    <= i_data;
                idpm_pkg::CFG_DOMAIN_KIND: r_cfg.domain_kind <= i_data[idpm_pkg::KIND_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

[sv/idpm_checker.sv]
// ----------------------------------------------------------------------------
// idpm_checker
// Port-level checks on the membership block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module idpm_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_in_ready,
    input wire logic                          i_out_valid,
    input wire logic                          i_out_ready,
    input wire logic                          i_out_inside,
    input wire logic [idpm_pkg::ERR_W-1:0]    i_out_error
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_inside) && $stable(i_out_error))
        else $error("stalled result changed or dropped");

    a_inside_no_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_inside |-> i_out_error == idpm_pkg::ERR_NONE)
        else $error("inside result carries an error");

    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_error <= idpm_pkg::ERR_LINE)
        else $error("unused error code");

    // clearing pass blocks transfers straight after reset
    a_clear_blocks: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready && !i_out_valid)
        else $error("item channel open during clearing pass");

endmodule

bind interval_domain_point_membership idpm_checker u_idpm_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_inside (o_out.inside_res),
    .i_out_error  (o_out.error)
);

`default_nettype wire

[tb/interval_domain_point_membership_tb.sv]
// ----------------------------------------------------------------------------
// interval_domain_point_membership_tb
// Self-checking bench for the interval domain point membership block. A short
// directed run covers the box extremes, every operation and every error code.
// Random phases then build ordered interval lines and query around their ends,
// mixed with stray writes and points, under several box settings and kinds.
// Both channels idle at random, and the result side holds off once for long
// enough to back the block up. A scoreboard predicts every result and checks
// them in order.
// ----------------------------------------------------------------------------
`default_nettype none

module interval_domain_point_membership_tb;

    localparam int LINES = 1024;
    localparam int SLOTS = 16;

    localparam logic [idpm_pkg::OP_W-1:0]   OP_UNUSED      = 2'd3;
    localparam logic [idpm_pkg::KIND_W-1:0] KIND_UNKNOWN_A = 2'd2;
    localparam logic [idpm_pkg::KIND_W-1:0] KIND_UNKNOWN_B = 2'd3;

    typedef struct packed {
        logic [idpm_pkg::OP_W-1:0]           op;
        logic [idpm_pkg::OFF_W-1:0]          line_offset;
        logic [idpm_pkg::SLOT_W-1:0]         slot;
        logic [idpm_pkg::COORD_W-1:0]        interval_left;
        logic [idpm_pkg::COORD_W-1:0]        interval_right;
        logic [idpm_pkg::CNT_IN_W-1:0]       count;
        logic signed [idpm_pkg::COORD_W-1:0] point_line;
        logic signed [idpm_pkg::COORD_W-1:0] point_col;
    } t_req;

    typedef struct packed {
        logic                       hit;
        logic [idpm_pkg::ERR_W-1:0] err;
    } t_verdict;

    class membership_scoreboard;
        idpm_pkg::t_cfg                cfg;
        logic [idpm_pkg::ENTRY_W-1:0]  ivl_mem [0:LINES*SLOTS-1];
        logic [idpm_pkg::CNT_IN_W-1:0] line_cnt [0:LINES-1];
        t_verdict                      due [$];
        int                            mismatches;

        function new();
            cfg = '0;
            mismatches = 0;
            foreach (ivl_mem[k]) ivl_mem[k] = '0;
            foreach (line_cnt[k]) line_cnt[k] = '0;
        endfunction

        task report(input string msg);
            $display("%0t: mismatch: %s", $realtime, msg);
            mismatches++;
        endtask

        function int pending();
            return due.size();
        endfunction

        function void set_reg(input logic [idpm_pkg::CFG_IDX_W-1:0] idx,
                              input logic [idpm_pkg::COORD_W-1:0] data);
            case (idx)
                idpm_pkg::CFG_LINE_FIRST:  cfg.line_first = data;
                idpm_pkg::CFG_LINE_LAST:   cfg.line_last = data;
                idpm_pkg::CFG_COL_FIRST:   cfg.col_first = data;
                idpm_pkg::CFG_COL_LAST:    cfg.col_last = data;
                idpm_pkg::CFG_DOMAIN_KIND: cfg.domain_kind = data[idpm_pkg::KIND_W-1:0];
                default: ;
            endcase
        endfunction

        function logic line_hit(input int row, input int rel);
            int n;
            int k;
            logic [idpm_pkg::ENTRY_W-1:0] e;
            n = line_cnt[row];
            for (k = 0; k < n; k++) begin
                e = ivl_mem[row*SLOTS + k];
                if (rel < int'(e[idpm_pkg::COORD_W-1:0])) return 1'b0;
                if (rel <= int'(e[idpm_pkg::ENTRY_W-1:idpm_pkg::COORD_W])) return 1'b1;
            end
            return 1'b0;
        endfunction

        function t_verdict apply_item(input t_req r);
            t_verdict v;
            int row;
            int rel;
            v = '0;
            case (r.op)
                idpm_pkg::OP_WR_IVL: begin
                    if (int'(r.line_offset) >= LINES) begin
                        v.err = idpm_pkg::ERR_LINE;
                    end else if (int'(r.slot) < SLOTS) begin
                        ivl_mem[int'(r.line_offset)*SLOTS + int'(r.slot)] =
                            {r.interval_right, r.interval_left};
                    end
                end
                idpm_pkg::OP_WR_CNT: begin
                    if (int'(r.line_offset) >= LINES) begin
                        v.err = idpm_pkg::ERR_LINE;
                    end else begin
                        line_cnt[r.line_offset] = (int'(r.count) > SLOTS) ?
                                                  idpm_pkg::CNT_IN_W'(SLOTS) : r.count;
                    end
                end
                idpm_pkg::OP_QUERY: begin
                    if ($signed(r.point_line) >= $signed(cfg.line_first) &&
                        $signed(r.point_line) <= $signed(cfg.line_last) &&
                        $signed(r.point_col) >= $signed(cfg.col_first) &&
                        $signed(r.point_col) <= $signed(cfg.col_last)) begin
                        case (cfg.domain_kind)
                            idpm_pkg::KIND_RECT: v.hit = 1'b1;
                            idpm_pkg::KIND_IVL: begin
                                row = int'($signed(r.point_line)) -
                                      int'($signed(cfg.line_first));
                                rel = int'($signed(r.point_col)) -
                                      int'($signed(cfg.col_first));
                                if (row >= LINES) v.err = idpm_pkg::ERR_LINE;
                                else v.hit = line_hit(row, rel);
                            end
                            default: v.err = idpm_pkg::ERR_KIND;
                        endcase
                    end
                end
                default: ;
            endcase
            return v;
        endfunction

        function void note_item(input t_req r);
            due.push_back(apply_item(r));
        endfunction

        task check_result(input logic hit, input logic [idpm_pkg::ERR_W-1:0] err);
            t_verdict v;
            if (due.size() == 0) begin
                report($sformatf("result (%0b, %0d) with nothing pending", hit, err));
            end else begin
                v = due.pop_front();
                if (hit !== v.hit)
                    report($sformatf("inside_res %0b, predicted %0b", hit, v.hit));
                if (err !== v.err)
                    report($sformatf("error %0d, predicted %0d", err, v.err));
            end
        endtask
    endclass

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           cfg_we;
    logic [idpm_pkg::CFG_IDX_W-1:0] cfg_idx;
    logic [idpm_pkg::COORD_W-1:0]   cfg_data;

    idpm_in_if  in_ch();
    idpm_out_if out_ch();

    interval_domain_point_membership #(
        .MAX_LINES     (LINES),
        .MAX_INTERVALS (SLOTS)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    membership_scoreboard sb = new();

    bit [SLOTS-1:0] written_mask [0:LINES-1];
    int sent_items   = 0;
    int results_seen = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("interval_domain_point_membership_tb NOT OK");
        $finish;
    end

    // result side: random stalls, one quiet stretch and one long hold-off
    initial begin
        bit held;
        held = 1'b0;
        out_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (!held && results_seen >= 500) begin
                held = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (400) @(posedge i_clk);
            end else if (results_seen >= 900 && results_seen < 1200) begin
                out_ch.ready <= 1'b1;
            end else begin
                out_ch.ready <= ($urandom_range(0, 99) >= 17);
            end
        end
    end

    initial begin
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
                results_seen++;
                sb.check_result(out_ch.inside_res, out_ch.error);
            end
        end
    end

    function automatic int clamp16(input int v);
        return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
    endfunction

    function automatic int written_prefix(input int row);
        int k;
        k = 0;
        while (k < SLOTS && written_mask[row][k]) k++;
        return k;
    endfunction

    function automatic t_req point_query(input int pl, input int pc);
        t_req r;
        r = '0;
        r.op = idpm_pkg::OP_QUERY;
        r.point_line = idpm_pkg::COORD_W'(pl);
        r.point_col = idpm_pkg::COORD_W'(pc);
        return r;
    endfunction

    function automatic t_req random_item();
        t_req r;
        r.op = idpm_pkg::OP_QUERY;
        r.line_offset = idpm_pkg::OFF_W'($urandom_range(0, LINES - 1));
        r.slot = idpm_pkg::SLOT_W'($urandom_range(0, SLOTS - 1));
        r.interval_left = idpm_pkg::COORD_W'($urandom_range(0, 65535));
        r.interval_right = idpm_pkg::COORD_W'($urandom_range(0, 65535));
        r.count = idpm_pkg::CNT_IN_W'($urandom_range(0, 31));
        r.point_line = idpm_pkg::COORD_W'($urandom_range(0, 65535));
        r.point_col = idpm_pkg::COORD_W'($urandom_range(0, 65535));
        return r;
    endfunction

    task automatic send_item(input t_req r);
        if (!(sent_items >= 800 && sent_items < 1100)) begin
            while ($urandom_range(0, 99) < 17) begin
                in_ch.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        in_ch.valid          <= 1'b1;
        in_ch.operation      <= r.op;
        in_ch.line_offset    <= r.line_offset;
        in_ch.slot           <= r.slot;
        in_ch.interval_left  <= r.interval_left;
        in_ch.interval_right <= r.interval_right;
        in_ch.count          <= r.count;
        in_ch.point_line     <= r.point_line;
        in_ch.point_col      <= r.point_col;
        @(posedge i_clk);
        while (in_ch.ready !== 1'b1) @(posedge i_clk);
        sb.note_item(r);
        if (r.op == idpm_pkg::OP_WR_IVL) written_mask[r.line_offset][r.slot] = 1'b1;
        sent_items++;
    endtask

    task automatic settle();
        in_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic set_box(input int lf, input int ll, input int cf, input int cl,
                           input logic [idpm_pkg::KIND_W-1:0] kind);
        logic [idpm_pkg::CFG_IDX_W-1:0] idxs [5];
        logic [idpm_pkg::COORD_W-1:0]   vals [5];
        int k;
        idxs = '{idpm_pkg::CFG_LINE_FIRST, idpm_pkg::CFG_LINE_LAST,
                 idpm_pkg::CFG_COL_FIRST, idpm_pkg::CFG_COL_LAST,
                 idpm_pkg::CFG_DOMAIN_KIND};
        vals = '{idpm_pkg::COORD_W'(lf), idpm_pkg::COORD_W'(ll),
                 idpm_pkg::COORD_W'(cf), idpm_pkg::COORD_W'(cl),
                 idpm_pkg::COORD_W'(kind)};
        for (k = 0; k < 5; k++) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= idxs[k];
            cfg_data <= vals[k];
            @(posedge i_clk);
            sb.set_reg(idxs[k], vals[k]);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic int pick_row();
        int span;
        span = int'($signed(sb.cfg.line_last)) - int'($signed(sb.cfg.line_first));
        if (span < 0) return $urandom_range(0, LINES - 1);
        return $urandom_range(0, (span > LINES - 1) ? LINES - 1 : span);
    endfunction

    task automatic query_row(input int row);
        int n;
        int rel;
        logic [idpm_pkg::ENTRY_W-1:0] e;
        n = sb.line_cnt[row];
        if (n == 0 || $urandom_range(0, 4) == 0) begin
            rel = $urandom_range(0, 65535);
        end else begin
            e = sb.ivl_mem[row*SLOTS + $urandom_range(0, n - 1)];
            case ($urandom_range(0, 4))
                0: rel = int'(e[idpm_pkg::COORD_W-1:0]) - 1;
                1: rel = int'(e[idpm_pkg::COORD_W-1:0]);
                2: rel = int'(e[idpm_pkg::ENTRY_W-1:idpm_pkg::COORD_W]);
                3: rel = int'(e[idpm_pkg::ENTRY_W-1:idpm_pkg::COORD_W]) + 1;
                default: rel = (int'(e[idpm_pkg::COORD_W-1:0]) +
                                int'(e[idpm_pkg::ENTRY_W-1:idpm_pkg::COORD_W])) / 2;
            endcase
        end
        send_item(point_query(int'($signed(sb.cfg.line_first)) + row,
                              int'($signed(sb.cfg.col_first)) + rel));
    endtask

    // ordered intervals, then the count, then points around their ends
    task automatic build_line(input int row);
        t_req r;
        int n;
        int k;
        int pos;
        int left;
        int right;
        bit big;
        n = $urandom_range(0, SLOTS);
        big = ($urandom_range(0, 3) == 0);
        pos = $urandom_range(0, 20);
        for (k = 0; k < n; k++) begin
            left = pos + $urandom_range(0, big ? 1500 : 6);
            right = left + $urandom_range(0, big ? 1500 : 5);
            pos = right + 2;
            r = random_item();
            r.op = idpm_pkg::OP_WR_IVL;
            r.line_offset = idpm_pkg::OFF_W'(row);
            r.slot = idpm_pkg::SLOT_W'(k);
            r.interval_left = idpm_pkg::COORD_W'(left);
            r.interval_right = idpm_pkg::COORD_W'(right);
            send_item(r);
        end
        r = random_item();
        r.op = idpm_pkg::OP_WR_CNT;
        r.line_offset = idpm_pkg::OFF_W'(row);
        r.count = (n == SLOTS && $urandom_range(0, 1) == 1) ?
                  idpm_pkg::CNT_IN_W'($urandom_range(SLOTS, 31)) :
                  idpm_pkg::CNT_IN_W'(n);
        send_item(r);
        repeat ($urandom_range(2, 6)) query_row(row);
    endtask

    task automatic random_step();
        t_req r;
        int sel;
        int row;
        int p;
        int lspan;
        int cspan;
        sel = $urandom_range(0, 99);
        r = random_item();
        if (sel < 60) begin
            build_line(pick_row());
        end else if (sel < 78) begin
            if ($urandom_range(0, 2) != 0) begin
                lspan = int'($signed(sb.cfg.line_last)) - int'($signed(sb.cfg.line_first));
                cspan = int'($signed(sb.cfg.col_last)) - int'($signed(sb.cfg.col_first));
                r.point_line = idpm_pkg::COORD_W'(int'($signed(sb.cfg.line_first)) +
                                        $urandom_range(0, (lspan < 0) ? 0 : lspan));
                r.point_col = idpm_pkg::COORD_W'(int'($signed(sb.cfg.col_first)) +
                                       $urandom_range(0, (cspan < 0) ? 0 : cspan));
            end
            send_item(r);
        end else if (sel < 90) begin
            r.op = idpm_pkg::OP_WR_IVL;
            send_item(r);
        end else if (sel < 96) begin
            row = $urandom_range(0, LINES - 1);
            p = written_prefix(row);
            r.op = idpm_pkg::OP_WR_CNT;
            r.line_offset = idpm_pkg::OFF_W'(row);
            r.count = (p == SLOTS && $urandom_range(0, 1) == 1) ?
                      idpm_pkg::CNT_IN_W'($urandom_range(SLOTS, 31)) :
                      idpm_pkg::CNT_IN_W'($urandom_range(0, p));
            send_item(r);
        end else begin
            r.op = OP_UNUSED;
            send_item(r);
        end
    endtask

    initial begin
        t_req r;
        int k;
        int ph;
        int phase_end;
        int lf;
        int ll;
        int cf;
        int cl;
        int sel;

        i_rst_n              <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_idx              <= idpm_pkg::CFG_LINE_FIRST;
        cfg_data             <= '0;
        in_ch.valid          <= 1'b0;
        in_ch.operation      <= idpm_pkg::OP_QUERY;
        in_ch.line_offset    <= '0;
        in_ch.slot           <= '0;
        in_ch.interval_left  <= '0;
        in_ch.interval_right <= '0;
        in_ch.count          <= '0;
        in_ch.point_line     <= '0;
        in_ch.point_col      <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: rectangle of the single point (0, 0)
        send_item(point_query(0, 0));
        send_item(point_query(-32768, 32767));
        r = '1;
        r.op = OP_UNUSED;
        send_item(r);
        for (k = 0; k < SLOTS; k++) begin
            r = point_query(0, 0);
            r.op = idpm_pkg::OP_WR_IVL;
            r.slot = idpm_pkg::SLOT_W'(k);
            r.interval_left = idpm_pkg::COORD_W'(k * 4000);
            r.interval_right = idpm_pkg::COORD_W'(k * 4000 + 1999);
            send_item(r);
        end
        r = point_query(0, 0);
        r.op = idpm_pkg::OP_WR_CNT;
        r.count = '1;
        send_item(r);

        settle();
        set_box(-32768, 32767, -32768, 32767, idpm_pkg::KIND_IVL);
        send_item(point_query(-32768, -32768 + 1999));
        send_item(point_query(-32768, -32768 + 2000));
        send_item(point_query(-32768, 32767));
        send_item(point_query(-32768 + LINES, 0));
        send_item(point_query(32767, 0));

        settle();
        set_box(-32768, 32767, -32768, 32767, KIND_UNKNOWN_A);
        send_item(point_query(0, 0));
        settle();
        set_box(-32768, 32767, -32768, 32767, KIND_UNKNOWN_B);
        send_item(point_query(100, -5));

        for (ph = 0; ph < 12; ph++) begin
            settle();
            sel = ph % 6;
            if (sel < 4) begin
                lf = $urandom_range(0, 64000) - 32768;
                k = $urandom_range(0, 9);
                ll = clamp16(lf + ((k == 0) ? 0 : (k < 8) ? $urandom_range(1, LINES - 1) :
                                                       $urandom_range(LINES, 4000)));
                cf = $urandom_range(0, 40000) - 32768;
                cl = ($urandom_range(0, 3) == 0) ? clamp16(cf + $urandom_range(0, 300)) :
                                                   32767 - $urandom_range(0, 2000);
                set_box(lf, ll, cf, cl, idpm_pkg::KIND_IVL);
            end else begin
                lf = $urandom_range(0, 65535) - 32768;
                ll = clamp16(lf + $urandom_range(0, 2000) - 200);
                cf = $urandom_range(0, 65535) - 32768;
                cl = clamp16(cf + $urandom_range(0, 2000) - 200);
                set_box(lf, ll, cf, cl, (sel == 4) ? idpm_pkg::KIND_RECT :
                        ($urandom_range(0, 1) == 1) ? KIND_UNKNOWN_A : KIND_UNKNOWN_B);
            end
            phase_end = sent_items + 160;
            while (sent_items < phase_end) random_step();
        end

        settle();
        repeat (40) @(posedge i_clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending()));
        if (sb.mismatches == 0) begin
            $display("interval_domain_point_membership_tb OK");
        end else begin
            $display("interval_domain_point_membership_tb NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
sv/idpm_pkg.sv
sv/idpm_in_if.sv
sv/idpm_out_if.sv
sv/idpm_ram.sv
sv/idpm_cfg.sv
sv/interval_domain_point_membership.sv
sv/idpm_checker.sv
tb/interval_domain_point_membership_tb.sv
